/* rtl/hgpp_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, constants, register codes and types of the hex grid pixel picker.
package hgpp_pkg;

    // Port field widths.
    localparam int COORD_W   = 32;
    localparam int BOUND_W   = 16;
    localparam int INDEX_W   = 32;
    localparam int INV_W     = 32;
    localparam int REG_IDX_W = 3;
    localparam int DATA_W    = 32;

    // Internal datapath widths.
    localparam int DIFF_W     = COORD_W + 1;          // point minus origin
    localparam int SQRT3_W    = 27;                   // signed form of the Q1.24 constant
    localparam int PROD_W     = DIFF_W + SQRT3_W;     // sqrt3 * dx
    localparam int FRAC_SHIFT = 24;
    localparam int AX_W       = PROD_W - FRAC_SHIFT;  // 3qf and 3rf before scaling
    localparam int HALF_W     = INV_W / 2;            // halves of the inverse size
    localparam int PART_W     = AX_W + HALF_W + 1;    // one partial product
    localparam int SUM_W      = PART_W + 1;           // scaled value in Q.24
    localparam int TRUNC_W    = SUM_W - FRAC_SHIFT;   // integer part of the scaled value
    localparam int DIV_W      = 32;                   // operand of the divide by three
    localparam int FLOOR_W    = 31;                   // quotient and rounded coordinate
    localparam int REM_W      = FRAC_SHIFT + 2;       // remainder against 3 * 2^24
    localparam int ERR_W      = FRAC_SHIFT + 1;       // rounding error, at most half of 3 * 2^24
    localparam int CELL_W     = FLOOR_W + 2;          // coordinate after the fix-up
    localparam int WIDTH_W    = BOUND_W + 1;          // column count of the bounds

    // Pipeline layout.
    localparam int STAGES    = 11;
    localparam int ST_ROUND  = 6;
    localparam int ROUND_ST  = 2;
    localparam int ST_CELL   = 8;
    localparam int CELL_ST   = 3;
    localparam int SCALE_ST  = 6;

    // round(sqrt(3) * 2^24).
    localparam logic signed [SQRT3_W-1:0] SQRT3_Q24 = 27'sd29058991;
    // floor(u / 3) = (u * RECIP3) >> 33 for any 32 bit u.
    localparam logic [DIV_W-1:0] RECIP3      = 32'hAAAA_AAAB;
    localparam int               RECIP_SHIFT = 33;
    // Bias that makes the dividend non-negative: 3 * 2^29, and its quotient 2^29.
    localparam logic [DIV_W-1:0]   DIV_BIAS   = 32'd1610612736;
    localparam logic [FLOOR_W-1:0] FLOOR_BIAS = 31'd536870912;
    // Rounding divisor 3 * 2^24 and half of it.
    localparam logic [REM_W-1:0] ROUND_DEN  = 26'd50331648;
    localparam logic [REM_W-1:0] ROUND_HALF = 26'd25165824;

    // Reset value of the inverse cell size: 1.0 in Q8.24.
    localparam logic [INV_W-1:0] INV_RESET = 32'h0100_0000;

    // Configuration register indexes.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_ORIGIN_X    = 3'd0,
        REG_ORIGIN_Y    = 3'd1,
        REG_INV_SIZE    = 3'd2,
        REG_COLUMN_LOW  = 3'd3,
        REG_COLUMN_HIGH = 3'd4,
        REG_ROW_LOW     = 3'd5,
        REG_ROW_HIGH    = 3'd6
    } reg_index_t;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic signed [COORD_W-1:0] anchor_x;
        logic signed [COORD_W-1:0] anchor_y;
        logic        [INV_W-1:0]   inverse_cell_size;
        logic signed [BOUND_W-1:0] column_low;
        logic signed [BOUND_W-1:0] column_high;
        logic signed [BOUND_W-1:0] row_low;
        logic signed [BOUND_W-1:0] row_high;
    } cfg_t;

endpackage

/* rtl/hgpp_if.sv */
`timescale 1ns / 1ps
// Handshake channel interfaces for points, picked tiles and register writes.
interface hgpp_point_if;
    import hgpp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink (input valid, input point_x, input point_y, output ready);
endinterface

interface hgpp_tile_if;
    import hgpp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic signed [BOUND_W-1:0] cell_q;
    logic signed [BOUND_W-1:0] cell_r;
    logic        [INDEX_W-1:0] tile_index;

    modport source (output valid, output hit, output cell_q, output cell_r,
                    output tile_index, input ready);
    modport sink (input valid, input hit, input cell_q, input cell_r,
                  input tile_index, output ready);
endinterface

interface hgpp_cfg_if;
    import hgpp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/hgpp_cfg.sv */
`timescale 1ns / 1ps
// Configuration register file of the hex grid pixel picker.
module hgpp_cfg (
    input  logic          clk,
    input  logic          rst_n,
    hgpp_cfg_if.sink      wr,
    output hgpp_pkg::cfg_t cfg
);
    import hgpp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken.
    assign wr.ready = 1'b1;
    assign cfg      = cfg_reg;

    // Decode the register index; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr.valid)
        begin
            case (reg_index_t'(wr.index))
                REG_ORIGIN_X:    cfg_next.anchor_x          = $signed(wr.data[COORD_W-1:0]);
                REG_ORIGIN_Y:    cfg_next.anchor_y          = $signed(wr.data[COORD_W-1:0]);
                REG_INV_SIZE:    cfg_next.inverse_cell_size = wr.data[INV_W-1:0];
                REG_COLUMN_LOW:  cfg_next.column_low        = $signed(wr.data[BOUND_W-1:0]);
                REG_COLUMN_HIGH: cfg_next.column_high       = $signed(wr.data[BOUND_W-1:0]);
                REG_ROW_LOW:     cfg_next.row_low           = $signed(wr.data[BOUND_W-1:0]);
                REG_ROW_HIGH:    cfg_next.row_high          = $signed(wr.data[BOUND_W-1:0]);
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage with reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.anchor_x          <= '0;
            cfg_reg.anchor_y          <= '0;
            cfg_reg.inverse_cell_size <= INV_RESET;
            cfg_reg.column_low        <= '0;
            cfg_reg.column_high       <= '0;
            cfg_reg.row_low           <= '0;
            cfg_reg.row_high          <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/hgpp_scale.sv */
`timescale 1ns / 1ps
// Front stages: origin offset, sqrt(3) product and scaling by the inverse cell size.
module hgpp_scale (
    input  logic                                   clk,
    input  logic [hgpp_pkg::SCALE_ST-1:0]          en,
    input  logic signed [hgpp_pkg::COORD_W-1:0]    point_x,
    input  logic signed [hgpp_pkg::COORD_W-1:0]    point_y,
    input  hgpp_pkg::cfg_t                         cfg,
    output logic signed [hgpp_pkg::SUM_W-1:0]      wq,
    output logic signed [hgpp_pkg::SUM_W-1:0]      wr,
    output logic signed [hgpp_pkg::SUM_W-1:0]      ws
);
    import hgpp_pkg::*;

    logic signed [DIFF_W-1:0] dx_reg, dx_next;
    logic signed [DIFF_W-1:0] dy_reg, dy_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [DIFF_W-1:0] dy1_reg;
    logic signed [AX_W-1:0]   aq_reg, aq_next;
    logic signed [AX_W-1:0]   ar_reg, ar_next;
    logic signed [HALF_W:0]   inv_hi, inv_lo;
    logic signed [PART_W-1:0] qh_reg, qh_next, ql_reg, ql_next;
    logic signed [PART_W-1:0] rh_reg, rh_next, rl_reg, rl_next;
    logic signed [SUM_W-1:0]  wq4_reg, wq4_next, wr4_reg, wr4_next;
    logic signed [SUM_W-1:0]  wq_reg, wr_reg, ws_reg, ws_next;

    // Offset from the grid origin.
    always_comb
    begin
        dx_next = DIFF_W'(point_x) - DIFF_W'(cfg.anchor_x);
        dy_next = DIFF_W'(point_y) - DIFF_W'(cfg.anchor_y);
    end

    // sqrt(3) * dx in Q.40.
    assign prod_next = dx_reg * SQRT3_Q24;

    // Three times the fractional axial coordinates, Q.16.
    always_comb
    begin
        aq_next = AX_W'(prod_reg >>> FRAC_SHIFT) - AX_W'(dy1_reg);
        ar_next = AX_W'(dy1_reg) <<< 1;
    end

    // Partial products against the two halves of the inverse size.
    assign inv_hi = $signed({1'b0, cfg.inverse_cell_size[INV_W-1:HALF_W]});
    assign inv_lo = $signed({1'b0, cfg.inverse_cell_size[HALF_W-1:0]});

    always_comb
    begin
        qh_next = aq_reg * inv_hi;
        ql_next = aq_reg * inv_lo;
        rh_next = ar_reg * inv_hi;
        rl_next = ar_reg * inv_lo;
    end

    // Merge the halves; the low product is floored by 16 bits.
    always_comb
    begin
        wq4_next = SUM_W'(qh_reg) + SUM_W'(ql_reg >>> HALF_W);
        wr4_next = SUM_W'(rh_reg) + SUM_W'(rl_reg >>> HALF_W);
    end

    // The third cube component.
    assign ws_next = -wq4_reg - wr4_reg;

    // Stage registers, each loaded when its stage advances.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (en[1])
        begin
            prod_reg <= prod_next;
            dy1_reg  <= dy_reg;
        end
        if (en[2])
        begin
            aq_reg <= aq_next;
            ar_reg <= ar_next;
        end
        if (en[3])
        begin
            qh_reg <= qh_next;
            ql_reg <= ql_next;
            rh_reg <= rh_next;
            rl_reg <= rl_next;
        end
        if (en[4])
        begin
            wq4_reg <= wq4_next;
            wr4_reg <= wr4_next;
        end
        if (en[5])
        begin
            wq_reg <= wq4_reg;
            wr_reg <= wr4_reg;
            ws_reg <= ws_next;
        end
    end

    assign wq = wq_reg;
    assign wr = wr_reg;
    assign ws = ws_reg;

endmodule

/* rtl/hgpp_round.sv */
`timescale 1ns / 1ps
// Round one cube component to the nearest integer, ties to even, with its error.
module hgpp_round (
    input  logic                                 clk,
    input  logic [hgpp_pkg::ROUND_ST-1:0]        en,
    input  logic signed [hgpp_pkg::SUM_W-1:0]    w,
    output logic signed [hgpp_pkg::FLOOR_W-1:0]  rounded,
    output logic        [hgpp_pkg::ERR_W-1:0]    err
);
    import hgpp_pkg::*;

    logic signed [TRUNC_W-1:0]    t;
    logic        [DIV_W-1:0]      u;
    logic        [2*DIV_W-1:0]    recip_prod;
    logic        [FLOOR_W-1:0]    quo;
    logic signed [FLOOR_W-1:0]    fl_reg, fl_next;
    logic        [1:0]            tlo_reg;
    logic        [FRAC_SHIFT-1:0] low_reg;
    logic        [1:0]            m;
    logic        [REM_W-1:0]      rem;
    logic                         up;
    logic signed [FLOOR_W-1:0]    rnd_reg, rnd_next;
    logic        [ERR_W-1:0]      err_reg, err_next;

    // floor(w / (3 * 2^24)) = floor(floor(w / 2^24) / 3), by a reciprocal multiply.
    always_comb
    begin
        t          = TRUNC_W'(w >>> FRAC_SHIFT);
        u          = unsigned'(DIV_W'(t)) + DIV_BIAS;
        recip_prod = (2*DIV_W)'(u) * (2*DIV_W)'(RECIP3);
        quo        = recip_prod[RECIP_SHIFT +: FLOOR_W];
        fl_next    = $signed(quo - FLOOR_BIAS);
    end

    // Remainder against 3 * 2^24, then round half to even.
    always_comb
    begin
        m        = tlo_reg - 2'(fl_reg[1:0] * 2'd3);
        rem      = {m, low_reg};
        up       = (rem > ROUND_HALF) || ((rem == ROUND_HALF) && fl_reg[0]);
        err_next = up ? ERR_W'(ROUND_DEN - rem) : ERR_W'(rem);
        rnd_next = fl_reg + $signed({{(FLOOR_W-1){1'b0}}, up});
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            fl_reg  <= fl_next;
            tlo_reg <= t[1:0];
            low_reg <= w[FRAC_SHIFT-1:0];
        end
        if (en[1])
        begin
            rnd_reg <= rnd_next;
            err_reg <= err_next;
        end
    end

    assign rounded = rnd_reg;
    assign err     = err_reg;

endmodule

/* rtl/hgpp_cell.sv */
`timescale 1ns / 1ps
// Back stages: cube fix-up, bounds check and row-major tile index.
module hgpp_cell (
    input  logic                                 clk,
    input  logic [hgpp_pkg::CELL_ST-1:0]         en,
    input  logic signed [hgpp_pkg::FLOOR_W-1:0]  rq,
    input  logic signed [hgpp_pkg::FLOOR_W-1:0]  rr,
    input  logic signed [hgpp_pkg::FLOOR_W-1:0]  rs,
    input  logic        [hgpp_pkg::ERR_W-1:0]    eq,
    input  logic        [hgpp_pkg::ERR_W-1:0]    er,
    input  logic        [hgpp_pkg::ERR_W-1:0]    es,
    input  hgpp_pkg::cfg_t                       cfg,
    output logic                                 hit,
    output logic signed [hgpp_pkg::BOUND_W-1:0]  cell_q,
    output logic signed [hgpp_pkg::BOUND_W-1:0]  cell_r,
    output logic        [hgpp_pkg::INDEX_W-1:0]  tile_index
);
    import hgpp_pkg::*;

    logic signed [CELL_W-1:0]  q_reg, q_next, r_reg, r_next;
    logic signed [CELL_W-1:0]  ql, qh, rl, rh;
    logic                      hit9_reg, hit9_next;
    logic        [BOUND_W-1:0] dq_reg, dq_next, dr_reg, dr_next;
    logic        [BOUND_W-1:0] q9_reg, r9_reg;
    logic        [WIDTH_W-1:0] width_reg, width_next;
    logic [BOUND_W+WIDTH_W-1:0] row_base;
    logic                      hit_reg;
    logic        [BOUND_W-1:0] cq_reg, cq_next, cr_reg, cr_next;
    logic        [INDEX_W-1:0] idx_reg, idx_next;

    // Recompute the component with the strictly largest rounding error.
    always_comb
    begin
        q_next = CELL_W'(rq);
        r_next = CELL_W'(rr);
        if ((eq > er) && (eq > es))
        begin
            q_next = -CELL_W'(rr) - CELL_W'(rs);
        end
        else if (er > es)
        begin
            r_next = -CELL_W'(rq) - CELL_W'(rs);
        end
    end

    // Bounds check and offsets into the tile grid.
    always_comb
    begin
        ql         = CELL_W'(cfg.column_low);
        qh         = CELL_W'(cfg.column_high);
        rl         = CELL_W'(cfg.row_low);
        rh         = CELL_W'(cfg.row_high);
        hit9_next  = (q_reg >= ql) && (q_reg <= qh) && (r_reg >= rl) && (r_reg <= rh);
        dq_next    = BOUND_W'(q_reg - ql);
        dr_next    = BOUND_W'(r_reg - rl);
        width_next = WIDTH_W'(qh - ql + 1);
    end

    // Row-major index; a miss clears every field.
    always_comb
    begin
        row_base = dr_reg * width_reg;
        idx_next = row_base[INDEX_W-1:0] + INDEX_W'(dq_reg);
        cq_next  = q9_reg;
        cr_next  = r9_reg;
        if (!hit9_reg)
        begin
            idx_next = '0;
            cq_next  = '0;
            cr_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
        if (en[1])
        begin
            hit9_reg  <= hit9_next;
            dq_reg    <= dq_next;
            dr_reg    <= dr_next;
            width_reg <= width_next;
            q9_reg    <= q_reg[BOUND_W-1:0];
            r9_reg    <= r_reg[BOUND_W-1:0];
        end
        if (en[2])
        begin
            hit_reg <= hit9_reg;
            cq_reg  <= cq_next;
            cr_reg  <= cr_next;
            idx_reg <= idx_next;
        end
    end

    assign hit        = hit_reg;
    assign cell_q     = $signed(cq_reg);
    assign cell_r     = $signed(cr_reg);
    assign tile_index = idx_reg;

endmodule

/* rtl/hex_grid_pixel_pick.sv */
`timescale 1ns / 1ps
// Top level of the hex grid pixel picker: pipeline control and datapath wiring.
//
// Maps a world point (Q16.16) to the pointy-top hex cell under it and reports a hit
// flag, the axial q and r, and the row-major tile index; a miss returns zeros. The
// datapath is an eleven-stage pipeline that takes one point beat per clock while
// the output side is not stalled. Each stage holds its own valid bit and moves up
// whenever the stage ahead of it is free, so bubbles close up under back-pressure
// and a new point is taken while a finished result still waits in the output
// register. The deepest logic per stage is one multiply: sqrt(3) times the offset,
// the two halves of the inverse cell size, a 32 by 32 reciprocal multiply for the
// divide by three in rounding, and the row offset times the width for the index.
// Register writes take effect on the next cycle and should be made only while no
// point is in flight.
module hex_grid_pixel_pick (
    input  logic      clk,
    input  logic      rst_n,
    hgpp_point_if.sink  point,
    hgpp_tile_if.source tile,
    hgpp_cfg_if.sink    cfg
);
    import hgpp_pkg::*;

    cfg_t                          cfg_cur;
    logic [STAGES-1:0]             valid_reg, valid_next;
    logic [STAGES-1:0]             en;
    logic signed [SUM_W-1:0]       wq, wr, ws;
    logic signed [FLOOR_W-1:0]     rq, rr, rs;
    logic        [ERR_W-1:0]       eq, er, es;

    hgpp_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cfg),
        .cfg   (cfg_cur)
    );

    // A stage advances when it is empty or the stage ahead advances.
    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || tile.ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    // Valid bits travel with the data.
    always_comb
    begin
        valid_next[0] = en[0] ? point.valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign point.ready = en[0];
    assign tile.valid  = valid_reg[STAGES-1];

    hgpp_scale u_scale (
        .clk     (clk),
        .en      (en[SCALE_ST-1:0]),
        .point_x (point.point_x),
        .point_y (point.point_y),
        .cfg     (cfg_cur),
        .wq      (wq),
        .wr      (wr),
        .ws      (ws)
    );

    hgpp_round u_round_q (
        .clk     (clk),
        .en      (en[ST_ROUND +: ROUND_ST]),
        .w       (wq),
        .rounded (rq),
        .err     (eq)
    );

    hgpp_round u_round_r (
        .clk     (clk),
        .en      (en[ST_ROUND +: ROUND_ST]),
        .w       (wr),
        .rounded (rr),
        .err     (er)
    );

    hgpp_round u_round_s (
        .clk     (clk),
        .en      (en[ST_ROUND +: ROUND_ST]),
        .w       (ws),
        .rounded (rs),
        .err     (es)
    );

    hgpp_cell u_cell (
        .clk        (clk),
        .en         (en[ST_CELL +: CELL_ST]),
        .rq         (rq),
        .rr         (rr),
        .rs         (rs),
        .eq         (eq),
        .er         (er),
        .es         (es),
        .cfg        (cfg_cur),
        .hit        (tile.hit),
        .cell_q     (tile.cell_q),
        .cell_r     (tile.cell_r),
        .tile_index (tile.tile_index)
    );

endmodule

/* tb/sv/hex_grid_pixel_pick_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the hex grid pixel picker, with its own cell predictor.
module hex_grid_pixel_pick_tb;
    import hgpp_pkg::*;

    localparam int HALF_PERIOD      = 2;
    localparam int RESET_CYCLES     = 12;
    localparam int WATCHDOG_NS      = 2_000_000;
    localparam int IDLE_PCT         = 29;
    localparam int NOISE_PCT        = 12;
    localparam int REPORT_LIMIT     = 10;
    localparam int RANDOM_PHASES    = 6;
    localparam int POINTS_PER_PHASE = 75;
    localparam int STEADY_PHASE     = 2;
    localparam int REACH_CELLS      = 14;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    // Three quarters of a unit in y puts r exactly halfway between two cells at unit size.
    localparam logic signed [COORD_W-1:0] TIE_DY    = 32'sd49152;
    localparam logic signed [COORD_W-1:0] ONE_UNIT  = 32'sh0001_0000;
    localparam logic signed [BOUND_W-1:0] BOUND_MAX = 16'sh7FFF;
    localparam logic signed [BOUND_W-1:0] BOUND_MIN = 16'sh8000;
    localparam logic [INV_W-1:0]          INV_MAX   = 32'hFFFF_FFFF;

    // One picked tile as it leaves the block.
    typedef struct packed {
        logic                      hit;
        logic signed [BOUND_W-1:0] cell_q;
        logic signed [BOUND_W-1:0] cell_r;
        logic        [INDEX_W-1:0] tile_index;
    } pick_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    bit    steady = 1'b0;
    int    error_count = 0;
    cfg_t  live_cfg;
    pick_t expected_picks[$];

    hgpp_point_if point_bus ();
    hgpp_tile_if  tile_bus ();
    hgpp_cfg_if   cfg_bus ();

    hex_grid_pixel_pick dut (
        .clk   (clk),
        .rst_n (rst_n),
        .point (point_bus),
        .tile  (tile_bus),
        .cfg   (cfg_bus)
    );

    always #HALF_PERIOD clk = ~clk;

    // Random idle decision shared by both sides; off during the steady stretch.
    function automatic bit take_break();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    function automatic cfg_t make_cfg(input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
                                      input logic [INV_W-1:0] inv,
                                      input logic [BOUND_W-1:0] ql, input logic [BOUND_W-1:0] qh,
                                      input logic [BOUND_W-1:0] rl, input logic [BOUND_W-1:0] rh);
        cfg_t c;
        c.anchor_x          = ox;
        c.anchor_y          = oy;
        c.inverse_cell_size = inv;
        c.column_low        = ql;
        c.column_high       = qh;
        c.row_low           = rl;
        c.row_high          = rh;
        return c;
    endfunction

    // Multiply by the Q8.24 inverse size as two 16 bit halves, flooring the low part.
    function automatic longint scale_by_inverse(input longint a, input logic [INV_W-1:0] inv);
        longint hi;
        longint lo;
        hi = longint'(inv[INV_W-1:HALF_W]);
        lo = longint'(inv[HALF_W-1:0]);
        return a * hi + ((a * lo) >>> HALF_W);
    endfunction

    // Nearest integer of w / (3 * 2^24) with ties to even; err gets the distance to it.
    function automatic longint round_third(input longint w, output longint err);
        longint den;
        longint fl;
        longint rem;
        den = longint'(ROUND_DEN);
        fl = w / den;
        if (w < 0 && fl * den != w)
            fl = fl - 1;
        rem = w - fl * den;
        if (2 * rem > den || (2 * rem == den && fl[0]))
        begin
            err = den - rem;
            return fl + 1;
        end
        err = rem;
        return fl;
    endfunction

    // Predicts the tile that one point picks under the current register settings.
    function automatic pick_t pick_cell(input logic signed [COORD_W-1:0] px,
                                        input logic signed [COORD_W-1:0] py);
        longint dx;
        longint dy;
        longint wq;
        longint wr;
        longint q;
        longint r;
        longint s;
        longint eq;
        longint er;
        longint es;
        longint ql;
        longint qh;
        longint rl;
        longint rh;
        longint idx;
        pick_t  p;
        dx = longint'(px) - longint'($signed(live_cfg.anchor_x));
        dy = longint'(py) - longint'($signed(live_cfg.anchor_y));
        // Three times the fractional axial coordinates, scaled to Q.24.
        wq = scale_by_inverse(((longint'(SQRT3_Q24) * dx) >>> FRAC_SHIFT) - dy,
                              live_cfg.inverse_cell_size);
        wr = scale_by_inverse(2 * dy, live_cfg.inverse_cell_size);
        q = round_third(wq, eq);
        r = round_third(wr, er);
        s = round_third(-wq - wr, es);
        // Rebuild the component whose error is strictly the largest.
        if (eq > er && eq > es)
            q = -r - s;
        else if (er > es)
            r = -q - s;
        ql = longint'($signed(live_cfg.column_low));
        qh = longint'($signed(live_cfg.column_high));
        rl = longint'($signed(live_cfg.row_low));
        rh = longint'($signed(live_cfg.row_high));
        p = '0;
        if (q >= ql && q <= qh && r >= rl && r <= rh)
        begin
            idx = (r - rl) * (qh - ql + 1) + (q - ql);
            p.hit        = 1'b1;
            p.cell_q     = q[BOUND_W-1:0];
            p.cell_r     = r[BOUND_W-1:0];
            p.tile_index = idx[INDEX_W-1:0];
        end
        return p;
    endfunction

    function automatic string show_pick(input pick_t p);
        return $sformatf("hit=%0b q=%0d r=%0d index=%0d", p.hit, p.cell_q, p.cell_r,
                         p.tile_index);
    endfunction

    function automatic void flag_error(input string text);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%s", text);
    endfunction

    // Sends one point beat; valid stays high so the next beat can follow at once.
    task automatic send_point(input logic signed [COORD_W-1:0] px,
                              input logic signed [COORD_W-1:0] py);
        while (take_break())
        begin
            point_bus.valid <= 1'b0;
            @(posedge clk);
        end
        point_bus.valid   <= 1'b1;
        point_bus.point_x <= px;
        point_bus.point_y <= py;
        do
            @(posedge clk);
        while (!point_bus.ready);
        expected_picks.push_back(pick_cell(px, py));
    endtask

    // Stops sending and waits until every expected tile has come out.
    task automatic drain_picks();
        point_bus.valid <= 1'b0;
        while (expected_picks.size() != 0)
            @(posedge clk);
        repeat (STAGES + 4) @(posedge clk);
    endtask

    task automatic put_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
    endtask

    // Writes every register while the pipeline is empty; bound writes carry junk upper bits.
    task automatic load_settings(input cfg_t c);
        drain_picks();
        put_reg(REG_ORIGIN_X, c.anchor_x);
        put_reg(REG_ORIGIN_Y, c.anchor_y);
        put_reg(REG_INV_SIZE, c.inverse_cell_size);
        put_reg(REG_COLUMN_LOW, {16'($urandom), c.column_low});
        put_reg(REG_COLUMN_HIGH, {16'($urandom), c.column_high});
        put_reg(REG_ROW_LOW, {16'($urandom), c.row_low});
        put_reg(REG_ROW_HIGH, {16'($urandom), c.row_high});
        cfg_bus.valid <= 1'b0;
        live_cfg = c;
    endtask

    // Settings straight out of reset: unit cell size and the single cell at the origin.
    task automatic test_reset_state();
        send_point(32'sd0, 32'sd0);
        send_point(2 * ONE_UNIT, 32'sd0);
        send_point(COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MIN);
    endtask

    // Full bound range, extreme points, ties to even and equal rounding errors.
    task automatic test_full_range();
        load_settings(make_cfg('0, '0, INV_RESET, BOUND_MIN, BOUND_MAX, BOUND_MIN, BOUND_MAX));
        send_point(32'sd0, 32'sd0);
        send_point(COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MIN);
        send_point(COORD_MAX, COORD_MIN);
        send_point(COORD_MIN, COORD_MAX);
        send_point(32'sd0, TIE_DY);
        send_point(32'sd0, -TIE_DY);
        send_point(32'sd1, -32'sd1);
    endtask

    // Cells beyond the 16 bit coordinate range must miss.
    task automatic test_far_cells();
        load_settings(make_cfg(COORD_MIN, COORD_MIN, INV_RESET,
                               BOUND_MIN, BOUND_MAX, BOUND_MIN, BOUND_MAX));
        send_point(COORD_MAX, COORD_MAX);
        send_point(COORD_MAX, COORD_MIN);
        load_settings(make_cfg('0, '0, INV_MAX, BOUND_MIN, BOUND_MAX, BOUND_MIN, BOUND_MAX));
        send_point(ONE_UNIT, ONE_UNIT / 4);
        send_point(COORD_MAX, 32'sd0);
    endtask

    // A zero inverse size sends every point to the origin cell.
    task automatic test_zero_inverse();
        load_settings(make_cfg($urandom, $urandom, '0, -16'sd2, 16'sd2, -16'sd1, 16'sd3));
        send_point(COORD_MAX, COORD_MIN);
        send_point(32'sd12345, -32'sd999);
        load_settings(make_cfg('0, '0, '0, 16'sd1, 16'sd4, -16'sd1, 16'sd3));
        send_point(32'sd0, 32'sd0);
    endtask

    // A low bound above its high bound leaves no cell to hit.
    task automatic test_empty_bounds();
        load_settings(make_cfg('0, '0, INV_RESET, 16'sd5, 16'sd4, -16'sd4, 16'sd4));
        send_point(32'sd0, 32'sd0);
        send_point(5 * ONE_UNIT, 32'sd0);
        load_settings(make_cfg('0, '0, INV_RESET, -16'sd4, 16'sd4, 16'sd3, -16'sd3));
        send_point(32'sd0, 32'sd0);
    endtask

    // Random settings with points scattered around the grid window, plus some noise.
    task automatic test_random_points(input int points, input bit calm);
        cfg_t   c;
        int     sh;
        longint cell_span;
        longint reach;
        longint off_x;
        longint off_y;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        sh = $urandom_range(26, 18);
        c.inverse_cell_size = (32'd1 << sh) | ($urandom & ((32'd1 << sh) - 1));
        c.anchor_x    = 32'($urandom_range(32'h7FFF_FFFF)) - 32'h4000_0000;
        c.anchor_y    = 32'($urandom_range(32'h7FFF_FFFF)) - 32'h4000_0000;
        c.column_low  = -16'($urandom_range(12));
        c.column_high = c.column_low + 16'($urandom_range(24));
        c.row_low     = -16'($urandom_range(12));
        c.row_high    = c.row_low + 16'($urandom_range(24));
        load_settings(c);
        steady = calm;
        cell_span = (64'sd1 <<< 40) / longint'(c.inverse_cell_size);
        reach     = cell_span * REACH_CELLS;
        repeat (points)
        begin
            if ($urandom_range(99) < NOISE_PCT)
            begin
                px = $urandom;
                py = $urandom;
            end
            else
            begin
                off_x = longint'($urandom_range(32'(2 * reach))) - reach;
                off_y = longint'($urandom_range(32'(2 * reach))) - reach;
                px = c.anchor_x + off_x[COORD_W-1:0];
                py = c.anchor_y + off_y[COORD_W-1:0];
            end
            send_point(px, py);
        end
        steady = 1'b0;
    endtask

    // Tile side back-pressure.
    initial
    begin
        tile_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            tile_bus.ready <= !take_break();
        end
    end

    // Compare each tile beat with the oldest prediction.
    always @(posedge clk)
    begin
        pick_t seen;
        pick_t want;
        if (rst_n && tile_bus.valid && tile_bus.ready)
        begin
            seen.hit        = tile_bus.hit;
            seen.cell_q     = tile_bus.cell_q;
            seen.cell_r     = tile_bus.cell_r;
            seen.tile_index = tile_bus.tile_index;
            if (expected_picks.size() == 0)
                flag_error($sformatf("unexpected tile beat: %s", show_pick(seen)));
            else
            begin
                want = expected_picks.pop_front();
                if (seen.hit !== want.hit || seen.cell_q !== want.cell_q
                    || seen.cell_r !== want.cell_r || seen.tile_index !== want.tile_index)
                    flag_error($sformatf("tile mismatch: expected %s, got %s",
                                         show_pick(want), show_pick(seen)));
            end
        end
    end

    // Main sequence.
    initial
    begin
        point_bus.valid   = 1'b0;
        point_bus.point_x = '0;
        point_bus.point_y = '0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = REG_ORIGIN_X;
        cfg_bus.data      = '0;
        live_cfg = make_cfg('0, '0, INV_RESET, '0, '0, '0, '0);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_full_range();
        test_far_cells();
        test_zero_inverse();
        test_empty_bounds();
        for (int i = 0; i < RANDOM_PHASES; i++)
            test_random_points(POINTS_PER_PHASE, i == STEADY_PHASE);
        drain_picks();
        if (error_count == 0 && expected_picks.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #WATCHDOG_NS;
        $display("status: fail");
        $finish;
    end

endmodule
